### sv/rqst_pkg.sv
// ----------------------------------------------------------------------------
// rqst_pkg
// Shared types and codes for the ready queue with sleep timers.
// ----------------------------------------------------------------------------
package rqst_pkg;

  // input word
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  thread_id;
    logic [31:0] sleep_ticks;
  } item_t;

  // result word
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] thread_out;
    logic [5:0] ready_level;
    logic [4:0] sleep_level;
    logic [4:0] woken;
  } result_t;

  // item kinds
  localparam logic [2:0] KIND_PUT    = 3'd0;
  localparam logic [2:0] KIND_GET    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_SLEEP  = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_GET_TAKE, S_RM_REQ, S_RM_CMP, S_SH_REQ, S_SH_WR,
    S_RM_END, S_TK_REQ, S_TK_EVAL, S_TK_END, S_EMIT
  } state_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PUT, OP_SET_EMPTY, OP_SET_IGN, OP_GET_REQ, OP_GET_TAKE,
    OP_RM_REQ, OP_RM_CMP, OP_SH_REQ, OP_SH_WR, OP_RM_END, OP_SLEEP,
    OP_TK_REQ, OP_TK_EVAL, OP_TK_END
  } op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [2:0] kind;
    logic       id_zero;
    logic       ready_empty;
    logic       sleep_empty;
    logic       rm_hit;
    logic       rm_more;
    logic       sh_more;
    logic       tk_more;
  } dp_stat_t;

endpackage

### sv/rqst_ram.sv
// ----------------------------------------------------------------------------
// rqst_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rqst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/rqst_dp.sv
// ----------------------------------------------------------------------------
// rqst_dp
// Datapath: ready queue and sleep list stores, pointers, counters, result.
// ----------------------------------------------------------------------------
module rqst_dp #(
  parameter int READY_DEPTH = 32,
  parameter int SLEEP_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rqst_pkg::op_t     op,
  input  rqst_pkg::item_t   in_word,
  output rqst_pkg::dp_stat_t stat,
  output rqst_pkg::result_t out_word
);

  localparam int IDW = (ID_BITS < 8) ? ID_BITS : 8;
  localparam int RIW = $clog2(READY_DEPTH);
  localparam int RCW = $clog2(READY_DEPTH + 1);
  localparam int SIW = $clog2(SLEEP_DEPTH);
  localparam int SCW = $clog2(SLEEP_DEPTH + 1);
  localparam int PSW = RIW + 2;

  // latched item
  logic [2:0]     kind_r;
  logic [IDW-1:0] id_r;
  logic [31:0]    ticks_r;

  // control registers
  logic [RIW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [RCW-1:0] count_r, count_nxt, ri_r, ri_nxt, rj_r, rj_nxt;
  logic [SCW-1:0] scount_r, scount_nxt, si_r, si_nxt, sj_r, sj_nxt;
  logic [SCW-1:0] woken_r, woken_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [IDW-1:0] taken_r, taken_nxt;

  // ram ports
  logic                r_we, s_we;
  logic [RIW-1:0]      r_waddr, r_raddr;
  logic [IDW-1:0]      r_wdata, r_rdata;
  logic [SIW-1:0]      s_waddr, s_raddr;
  logic [IDW+31:0]     s_wdata, s_rdata;

  logic [RIW-1:0] pos_i, pos_j, pos_j1, pos_last, tail_inc, head_inc;
  logic [IDW-1:0] s_id;
  logic [31:0]    s_left;

  // ring position of head plus an offset, one compare and subtract
  function automatic logic [RIW-1:0] ring_pos(input logic [RIW-1:0] base,
                                              input logic [RCW:0] offs);
    logic [PSW-1:0] sum;
    sum = PSW'(base) + PSW'(offs);
    if (sum >= PSW'(READY_DEPTH)) begin
      sum = sum - PSW'(READY_DEPTH);
    end
    return sum[RIW-1:0];
  endfunction

  function automatic logic [RIW-1:0] wrap_next(input logic [RIW-1:0] p);
    return (p == RIW'(READY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pos_i    = ring_pos(head_r, {1'b0, ri_r});
  assign pos_j    = ring_pos(head_r, {1'b0, rj_r});
  assign pos_j1   = ring_pos(head_r, {1'b0, rj_r} + 1'b1);
  assign pos_last = ring_pos(head_r, {1'b0, count_r} - 1'b1);
  assign tail_inc = wrap_next(tail_r);
  assign head_inc = wrap_next(head_r);
  assign s_id     = s_rdata[IDW+31:32];
  assign s_left   = s_rdata[31:0] - 32'd1;

  // storage
  rqst_ram #(.WIDTH(IDW), .DEPTH(READY_DEPTH)) u_ready_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  rqst_ram #(.WIDTH(IDW + 32), .DEPTH(SLEEP_DEPTH)) u_sleep_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // operation decode
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    ri_nxt     = ri_r;
    rj_nxt     = rj_r;
    scount_nxt = scount_r;
    si_nxt     = si_r;
    sj_nxt     = sj_r;
    woken_nxt  = woken_r;
    status_nxt = status_r;
    taken_nxt  = taken_r;
    r_we       = 1'b0;
    r_waddr    = tail_r;
    r_wdata    = id_r;
    r_raddr    = head_r;
    s_we       = 1'b0;
    s_waddr    = sj_r[SIW-1:0];
    s_wdata    = {id_r, ticks_r};
    s_raddr    = si_r[SIW-1:0];
    unique case (op)
      rqst_pkg::OP_LOAD: begin
        ri_nxt     = '0;
        rj_nxt     = '0;
        si_nxt     = '0;
        sj_nxt     = '0;
        woken_nxt  = '0;
        taken_nxt  = '0;
        status_nxt = rqst_pkg::ST_OK;
      end
      rqst_pkg::OP_PUT: begin
        if (count_r >= RCW'(READY_DEPTH)) begin
          status_nxt = rqst_pkg::ST_OVERFLOW;
        end else begin
          r_we      = 1'b1;
          tail_nxt  = tail_inc;
          count_nxt = count_r + 1'b1;
        end
      end
      rqst_pkg::OP_SET_EMPTY: status_nxt = rqst_pkg::ST_EMPTY;
      rqst_pkg::OP_SET_IGN:   status_nxt = rqst_pkg::ST_IGNORED;
      rqst_pkg::OP_GET_REQ:   r_raddr = head_r;
      rqst_pkg::OP_GET_TAKE: begin
        taken_nxt = r_rdata;
        head_nxt  = head_inc;
        count_nxt = count_r - 1'b1;
      end
      rqst_pkg::OP_RM_REQ: r_raddr = pos_i;
      rqst_pkg::OP_RM_CMP: begin
        if (r_rdata == id_r) begin
          rj_nxt = ri_r;
        end else begin
          ri_nxt = ri_r + 1'b1;
          if (!stat.rm_more) begin
            status_nxt = rqst_pkg::ST_EMPTY;
          end
        end
      end
      rqst_pkg::OP_SH_REQ: r_raddr = pos_j1;
      rqst_pkg::OP_SH_WR: begin
        r_we    = 1'b1;
        r_waddr = pos_j;
        r_wdata = r_rdata;
        rj_nxt  = rj_r + 1'b1;
      end
      rqst_pkg::OP_RM_END: begin
        tail_nxt  = pos_last;
        count_nxt = count_r - 1'b1;
      end
      rqst_pkg::OP_SLEEP: begin
        if (id_r == '0 || ticks_r == '0) begin
          status_nxt = rqst_pkg::ST_IGNORED;
        end else if (scount_r >= SCW'(SLEEP_DEPTH)) begin
          status_nxt = rqst_pkg::ST_OVERFLOW;
        end else begin
          s_we       = 1'b1;
          s_waddr    = scount_r[SIW-1:0];
          scount_nxt = scount_r + 1'b1;
        end
      end
      rqst_pkg::OP_TK_REQ: s_raddr = si_r[SIW-1:0];
      rqst_pkg::OP_TK_EVAL: begin
        si_nxt = si_r + 1'b1;
        if (s_left == '0) begin
          if (count_r >= RCW'(READY_DEPTH)) begin
            status_nxt = rqst_pkg::ST_OVERFLOW;
          end else begin
            r_we      = 1'b1;
            r_wdata   = s_id;
            tail_nxt  = tail_inc;
            count_nxt = count_r + 1'b1;
            woken_nxt = woken_r + 1'b1;
          end
        end else begin
          s_we    = 1'b1;
          s_wdata = {s_id, s_left};
          sj_nxt  = sj_r + 1'b1;
        end
      end
      rqst_pkg::OP_TK_END: scount_nxt = sj_r;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      scount_r <= '0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      scount_r <= scount_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (op == rqst_pkg::OP_LOAD) begin
      kind_r  <= in_word.kind;
      id_r    <= in_word.thread_id[IDW-1:0];
      ticks_r <= in_word.sleep_ticks;
    end
    ri_r     <= ri_nxt;
    rj_r     <= rj_nxt;
    si_r     <= si_nxt;
    sj_r     <= sj_nxt;
    woken_r  <= woken_nxt;
    status_r <= status_nxt;
    taken_r  <= taken_nxt;
  end

  // status to controller
  always_comb begin
    stat.kind        = kind_r;
    stat.id_zero     = (id_r == '0);
    stat.ready_empty = (count_r == '0);
    stat.sleep_empty = (scount_r == '0);
    stat.rm_hit      = (r_rdata == id_r);
    stat.rm_more     = ({1'b0, ri_r} + 1'b1) < {1'b0, count_r};
    stat.sh_more     = ({1'b0, rj_r} + 2'd2) < {1'b0, count_r};
    stat.tk_more     = ({1'b0, si_r} + 1'b1) < {1'b0, scount_r};
  end

  // result word
  always_comb begin
    out_word.status      = status_r;
    out_word.thread_out  = 8'(taken_r);
    out_word.ready_level = 6'(count_r);
    out_word.sleep_level = 5'(scount_r);
    out_word.woken       = 5'(woken_r);
  end

endmodule

### sv/rqst_ctrl.sv
// ----------------------------------------------------------------------------
// rqst_ctrl
// Controller: sequences each item through datapath operations.
// ----------------------------------------------------------------------------
module rqst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rqst_pkg::dp_stat_t stat,
  output rqst_pkg::op_t      op,
  output logic               busy,
  output logic               out_valid
);

  rqst_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rqst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and operation
  always_comb begin
    state_nxt = state_r;
    op        = rqst_pkg::OP_NONE;
    busy      = (state_r != rqst_pkg::S_IDLE);
    out_valid = (state_r == rqst_pkg::S_EMIT);
    unique case (state_r)
      rqst_pkg::S_IDLE: begin
        if (start) begin
          op        = rqst_pkg::OP_LOAD;
          state_nxt = rqst_pkg::S_DISP;
        end
      end
      rqst_pkg::S_DISP: begin
        state_nxt = rqst_pkg::S_EMIT;
        case (stat.kind)
          rqst_pkg::KIND_PUT: op = rqst_pkg::OP_PUT;
          rqst_pkg::KIND_GET: begin
            if (stat.ready_empty) begin
              op = rqst_pkg::OP_SET_EMPTY;
            end else begin
              op        = rqst_pkg::OP_GET_REQ;
              state_nxt = rqst_pkg::S_GET_TAKE;
            end
          end
          rqst_pkg::KIND_REMOVE: begin
            if (stat.id_zero) begin
              op = rqst_pkg::OP_SET_IGN;
            end else if (stat.ready_empty) begin
              op = rqst_pkg::OP_SET_EMPTY;
            end else begin
              state_nxt = rqst_pkg::S_RM_REQ;
            end
          end
          rqst_pkg::KIND_SLEEP: op = rqst_pkg::OP_SLEEP;
          rqst_pkg::KIND_TICK: begin
            if (!stat.sleep_empty) begin
              state_nxt = rqst_pkg::S_TK_REQ;
            end
          end
          default: op = rqst_pkg::OP_SET_IGN;
        endcase
      end
      rqst_pkg::S_GET_TAKE: begin
        op        = rqst_pkg::OP_GET_TAKE;
        state_nxt = rqst_pkg::S_EMIT;
      end
      rqst_pkg::S_RM_REQ: begin
        op        = rqst_pkg::OP_RM_REQ;
        state_nxt = rqst_pkg::S_RM_CMP;
      end
      rqst_pkg::S_RM_CMP: begin
        op = rqst_pkg::OP_RM_CMP;
        if (stat.rm_hit) begin
          state_nxt = stat.rm_more ? rqst_pkg::S_SH_REQ : rqst_pkg::S_RM_END;
        end else begin
          state_nxt = stat.rm_more ? rqst_pkg::S_RM_REQ : rqst_pkg::S_EMIT;
        end
      end
      rqst_pkg::S_SH_REQ: begin
        op        = rqst_pkg::OP_SH_REQ;
        state_nxt = rqst_pkg::S_SH_WR;
      end
      rqst_pkg::S_SH_WR: begin
        op        = rqst_pkg::OP_SH_WR;
        state_nxt = stat.sh_more ? rqst_pkg::S_SH_REQ : rqst_pkg::S_RM_END;
      end
      rqst_pkg::S_RM_END: begin
        op        = rqst_pkg::OP_RM_END;
        state_nxt = rqst_pkg::S_EMIT;
      end
      rqst_pkg::S_TK_REQ: begin
        op        = rqst_pkg::OP_TK_REQ;
        state_nxt = rqst_pkg::S_TK_EVAL;
      end
      rqst_pkg::S_TK_EVAL: begin
        op        = rqst_pkg::OP_TK_EVAL;
        state_nxt = stat.tk_more ? rqst_pkg::S_TK_REQ : rqst_pkg::S_TK_END;
      end
      rqst_pkg::S_TK_END: begin
        op        = rqst_pkg::OP_TK_END;
        state_nxt = rqst_pkg::S_EMIT;
      end
      rqst_pkg::S_EMIT: state_nxt = rqst_pkg::S_IDLE;
      default: state_nxt = rqst_pkg::S_IDLE;
    endcase
  end

endmodule

### sv/ready_queue_with_sleep_timers.sv
// One word at a time, paced by the walks over the ready and sleep RAMs: put,
// sleep and ignored words at dispatch; get reads the head, then takes it;
// remove compares entries in turn, shifts later ones down, trims the tail;
// tick walks the sleepers. The next word is taken in the cycle after each
// result strobe, which the receiver cannot hold off. Synchronous active-low
// reset clears the pointers, counts and controller; RAM contents are kept.
// ----------------------------------------------------------------------------
// ready_queue_with_sleep_timers
// Thread scheduler: FIFO ready queue plus an ordered list of sleepers.
// ----------------------------------------------------------------------------
module ready_queue_with_sleep_timers #(
  parameter int READY_DEPTH = 32,
  parameter int SLEEP_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rqst_pkg::item_t   in_word,
  output logic              out_valid,
  output rqst_pkg::result_t out_word
);

  rqst_pkg::op_t      op;
  rqst_pkg::dp_stat_t stat;

  // sequencing
  rqst_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
    .op(op), .busy(busy), .out_valid(out_valid)
  );

  // stores and arithmetic
  rqst_dp #(
    .READY_DEPTH(READY_DEPTH), .SLEEP_DEPTH(SLEEP_DEPTH), .ID_BITS(ID_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op), .in_word(in_word),
    .stat(stat), .out_word(out_word)
  );

endmodule

### sv/rqst_checker.sv
// ----------------------------------------------------------------------------
// rqst_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rqst_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input rqst_pkg::result_t out_word
);

  // an accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after accept");

  // a result strobe comes while the word is still in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  // one strobe per word
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe held");

  // a popped id only with an ok status
  a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.thread_out != 8'd0 |-> out_word.status == rqst_pkg::ST_OK)
    else $error("id returned with bad status");

endmodule

bind ready_queue_with_sleep_timers rqst_checker u_rqst_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_word(out_word)
);
